// ===== rtl/ptpd_pkg.sv =====
// Shared constants and types for the perspective-divide point transform.
// Used by the channel interfaces, the divider pipeline and the top level.
package ptpd_pkg;

    // Fixed-point format of matrix entries, points and results.
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int ACC_W     = 64;

    // Configuration register file.
    localparam int N_REGS    = 8;
    localparam int REG_SEL_W = 3;
    localparam int IDX_W     = 4;

    // Quotient bits kept by the divider: one step per stage.
    localparam int Q_BITS    = WORD_W + 1;

    // Internal stages: multiply, three accumulate, divide prep, divide steps.
    localparam int STAGES    = 5 + Q_BITS;

    // Saturation limits on the quotient magnitude.
    localparam logic [Q_BITS-1:0] POS_LIM = Q_BITS'(64'h0000_0000_7FFF_FFFF);
    localparam logic [Q_BITS-1:0] NEG_LIM = Q_BITS'(64'h0000_0000_8000_0000);

    // Side information that travels alongside the divider lanes.
    typedef struct packed {
        logic [2:0] neg;
        logic [2:0] ovf;
        logic       w_zero;
        logic       fault;
    } t_side;

    // One result word.
    typedef struct packed {
        logic signed [WORD_W-1:0] result_x;
        logic signed [WORD_W-1:0] result_y;
        logic signed [WORD_W-1:0] result_z;
        logic                     range_fault;
    } t_res;

endpackage

// ===== rtl/ptpd_if.sv =====
// Valid/ready channel interfaces for points, results and configuration writes.
// Depends on ptpd_pkg for field widths.
interface ptpd_cfg_if import ptpd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [ACC_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface ptpd_point_if import ptpd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] point_x;
    logic signed [WORD_W-1:0] point_y;
    logic signed [WORD_W-1:0] point_z;
    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ptpd_result_if import ptpd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] result_x;
    logic signed [WORD_W-1:0] result_y;
    logic signed [WORD_W-1:0] result_z;
    logic                     range_fault;
    modport source (output valid, output result_x, output result_y, output result_z,
                    output range_fault, input ready);
    modport sink   (input valid, input result_x, input result_y, input result_z,
                    input range_fault, output ready);
endinterface

// ===== rtl/point_transform_perspective_divide.sv =====
// Homogeneous 4x4 point transform with perspective divide.
// Channels: i_point takes one word (x, y, z) in signed Q16.16; o_result gives
// one word (x/w, y/w, z/w, range_fault) per point, in order. i_cfg writes one
// 64-bit matrix register per word; it is always ready, and an index above
// seven is ignored. Write the matrix only while no point is in flight.
// Throughput: one point per cycle while the skid register is empty. The
// multiply register loads at the edge that accepts a point; then come three
// saturating accumulate stages, one divide-prep stage, the 33-stage
// restoring divider (one quotient bit per stage per lane) and the output
// register.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the output register holds its word and a skid
// register catches one more; i_point.ready drops only once the skid register
// is full, and the whole pipeline then holds without loss.
// A zero w gives zero coordinates with range_fault set; saturation of any
// accumulator or quotient also sets range_fault.
module point_transform_perspective_divide import ptpd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptpd_cfg_if.sink      i_cfg,
    ptpd_point_if.sink    i_point,
    ptpd_result_if.source o_result
);

    localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << FRAC_BITS;

    // Saturating 64-bit add; the top bit of the result is the overflow flag.
    function automatic logic [ACC_W:0] sat_add(logic [ACC_W-1:0] a, logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
        end
        return {1'b0, s[ACC_W-1:0]};
    endfunction

    // Matrix registers.
    logic [ACC_W-1:0] r_matrix [N_REGS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix[0] <= ONE;
            r_matrix[1] <= '0;
            r_matrix[2] <= ONE << WORD_W;
            r_matrix[3] <= '0;
            r_matrix[4] <= '0;
            r_matrix[5] <= ONE;
            r_matrix[6] <= '0;
            r_matrix[7] <= ONE << WORD_W;
        end else if (i_cfg.valid && i_cfg.ready && (i_cfg.index < IDX_W'(N_REGS))) begin
            r_matrix[i_cfg.index[REG_SEL_W-1:0]] <= i_cfg.data;
        end
    end

    // Unpack the entries M[row][col].
    logic signed [WORD_W-1:0] m  [4][4];
    logic signed [WORD_W-1:0] pt [3];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (c % 2 == 1) begin
                    m[r][c] = r_matrix[REG_SEL_W'(r * 2 + c / 2)][ACC_W-1:WORD_W];
                end else begin
                    m[r][c] = r_matrix[REG_SEL_W'(r * 2 + c / 2)][WORD_W-1:0];
                end
            end
        end
    end

    assign pt[0] = i_point.point_x;
    assign pt[1] = i_point.point_y;
    assign pt[2] = i_point.point_z;

    // Pipeline control: every stage moves together unless the skid is full.
    logic              r_sv;
    logic              r_ov;
    logic              en;
    logic [STAGES-1:0] r_v;

    assign en            = !r_sv;
    assign i_point.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[STAGES-2:0], i_point.valid};
        end
    end

    // Stage 0: products and translation terms.
    logic signed [ACC_W-1:0] r_prod [4][3];
    logic        [ACC_W-1:0] r_tr   [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[c][k] <= pt[k] * m[k][c];
                end
                r_tr[c] <= {{(ACC_W-WORD_W-FRAC_BITS){m[3][c][WORD_W-1]}}, m[3][c],
                            {FRAC_BITS{1'b0}}};
            end
        end
    end

    // Stages 1 to 3: saturating accumulation, one term per stage.
    logic [ACC_W-1:0] r_acc_a [4];
    logic [ACC_W-1:0] r_acc_b [4];
    logic [ACC_W-1:0] r_acc_c [4];
    logic [ACC_W-1:0] r_p1_a  [4];
    logic [ACC_W-1:0] r_p2_a  [4];
    logic [ACC_W-1:0] r_p2_b  [4];
    logic             r_flt_a;
    logic             r_flt_b;
    logic             r_flt_c;
    logic [ACC_W:0]   sum_a   [4];
    logic [ACC_W:0]   sum_b   [4];
    logic [ACC_W:0]   sum_c   [4];

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            sum_a[c] = sat_add(r_tr[c], r_prod[c][0]);
            sum_b[c] = sat_add(r_acc_a[c], r_p1_a[c]);
            sum_c[c] = sat_add(r_acc_b[c], r_p2_b[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_acc_a[c] <= sum_a[c][ACC_W-1:0];
                r_p1_a[c]  <= r_prod[c][1];
                r_p2_a[c]  <= r_prod[c][2];
                r_acc_b[c] <= sum_b[c][ACC_W-1:0];
                r_p2_b[c]  <= r_p2_a[c];
                r_acc_c[c] <= sum_c[c][ACC_W-1:0];
            end
            r_flt_a <= sum_a[0][ACC_W] | sum_a[1][ACC_W] | sum_a[2][ACC_W] | sum_a[3][ACC_W];
            r_flt_b <= r_flt_a | sum_b[0][ACC_W] | sum_b[1][ACC_W] | sum_b[2][ACC_W]
                       | sum_b[3][ACC_W];
            r_flt_c <= r_flt_b | sum_c[0][ACC_W] | sum_c[1][ACC_W] | sum_c[2][ACC_W]
                       | sum_c[3][ACC_W];
        end
    end

    // Stage 4: magnitudes, overflow check and the bits the divider shifts in.
    logic [ACC_W-1:0]  mag_w;
    logic [ACC_W-1:0]  mag_n   [3];
    logic [ACC_W-1:0]  rem0    [3];
    logic [ACC_W-1:0]  r_rem0  [3];
    logic [ACC_W-1:0]  r_den   [3];
    logic [Q_BITS-1:0] r_bits  [3];
    t_side             n_side;
    t_side             r_side_p;

    always_comb begin
        mag_w = r_acc_c[3][ACC_W-1] ? (~r_acc_c[3] + ACC_W'(1)) : r_acc_c[3];
        n_side.w_zero = (r_acc_c[3] == '0);
        n_side.fault  = r_flt_c;
        for (int c = 0; c < 3; c++) begin
            mag_n[c] = r_acc_c[c][ACC_W-1] ? (~r_acc_c[c] + ACC_W'(1)) : r_acc_c[c];
            rem0[c]  = mag_n[c] >> (Q_BITS - FRAC_BITS);
            n_side.neg[c] = r_acc_c[c][ACC_W-1] ^ r_acc_c[3][ACC_W-1];
            n_side.ovf[c] = (rem0[c] >= mag_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_rem0[c] <= rem0[c];
                r_den[c]  <= mag_w;
                r_bits[c] <= {mag_n[c][Q_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            end
            r_side_p <= n_side;
        end
    end

    // Stages 5 onward: one divider lane per coordinate.
    logic [Q_BITS-1:0] quo    [3];
    t_side             r_side [Q_BITS];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        ptpd_div_pipe u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (r_rem0[c]),
            .i_den  (r_den[c]),
            .i_bits (r_bits[c]),
            .o_quo  (quo[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_side_p;
            for (int j = 1; j < Q_BITS; j++) begin
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // Sign, saturation and the zero-w case.
    t_side             side_o;
    logic [WORD_W-1:0] res   [3];
    logic [2:0]        sat;
    t_res              n_res;

    assign side_o = r_side[Q_BITS-1];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sat[c] = 1'b0;
            if (side_o.w_zero) begin
                res[c] = '0;
            end else if (side_o.neg[c]) begin
                if (side_o.ovf[c] || (quo[c] > NEG_LIM)) begin
                    res[c] = NEG_LIM[WORD_W-1:0];
                    sat[c] = 1'b1;
                end else begin
                    res[c] = ~quo[c][WORD_W-1:0] + WORD_W'(1);
                end
            end else begin
                if (side_o.ovf[c] || (quo[c] > POS_LIM)) begin
                    res[c] = POS_LIM[WORD_W-1:0];
                    sat[c] = 1'b1;
                end else begin
                    res[c] = quo[c][WORD_W-1:0];
                end
            end
        end
        n_res.result_x    = res[0];
        n_res.result_y    = res[1];
        n_res.result_z    = res[2];
        n_res.range_fault = side_o.fault | side_o.w_zero | (|sat);
    end

    // Output register with a one-word skid behind it.
    t_res r_out;
    t_res r_skid;
    logic take;
    logic arrive;

    assign take   = r_ov && o_result.ready;
    assign arrive = en && r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (arrive) begin
            if (r_ov && !take) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (arrive) begin
            if (r_ov && !take) begin
                r_skid <= n_res;
            end else begin
                r_out <= n_res;
            end
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.result_x    = r_out.result_x;
    assign o_result.result_y    = r_out.result_y;
    assign o_result.result_z    = r_out.result_z;
    assign o_result.range_fault = r_out.range_fault;

    // The skid register is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid word held with an empty output register");

    // A word arriving at a full, stalled output lands in the skid register.
    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (arrive && r_ov && !o_result.ready) |=> r_sv)
        else $error("word arriving at a stalled output was not caught");

    // While the pipeline holds, no stage gains or loses a word.
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipeline valid bits moved during a stall");

endmodule

// ===== rtl/ptpd_div_pipe.sv =====
// Pipelined restoring divider for one coordinate lane: one quotient bit per stage.
// Depends on ptpd_pkg for the quotient width.
module ptpd_div_pipe import ptpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ACC_W-1:0]  i_rem,
    input  logic [ACC_W-1:0]  i_den,
    input  logic [Q_BITS-1:0] i_bits,
    output logic [Q_BITS-1:0] o_quo
);

    logic [ACC_W-1:0]  r_rem  [Q_BITS];
    logic [ACC_W-1:0]  r_den  [Q_BITS];
    logic [Q_BITS-1:0] r_bits [Q_BITS];
    logic [Q_BITS-1:0] r_quo  [Q_BITS];

    for (genvar j = 0; j < Q_BITS; j++) begin : g_step
        logic [ACC_W-1:0]  rem_in;
        logic [ACC_W-1:0]  den_in;
        logic [Q_BITS-1:0] bits_in;
        logic [Q_BITS-1:0] quo_in;
        logic [ACC_W-1:0]  shifted;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign bits_in = i_bits;
            assign quo_in  = '0;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign den_in  = r_den[j-1];
            assign bits_in = r_bits[j-1];
            assign quo_in  = r_quo[j-1];
        end

        // The remainder stays below the divisor, so its top bit is always clear.
        assign shifted = {rem_in[ACC_W-2:0], bits_in[Q_BITS-1]};
        assign ge      = (shifted >= den_in);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? (shifted - den_in) : shifted;
                r_den[j]  <= den_in;
                r_bits[j] <= {bits_in[Q_BITS-2:0], 1'b0};
                r_quo[j]  <= {quo_in[Q_BITS-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[Q_BITS-1];

endmodule
